FILE: rtl/core/scsc_pkg.sv
// ----------------------------------------------------------------------------
// scsc_pkg: shared types and constants of the sprite command stream checker
// Holds the status and warning codes, the parse phases, the opcode range
// bounds and the structs that pass between the pipeline stages.
// ----------------------------------------------------------------------------
package scsc_pkg;

  // Number of bv entries that an index may address.
  localparam int BV_SIZE = 8;

  // Opcode range bounds.
  localparam logic [7:0] OP_END       = 8'h00;
  localparam logic [7:0] OP_LEN1      = 8'h20;
  localparam logic [7:0] OP_LEN2      = 8'h40;
  localparam logic [7:0] OP_LEN3      = 8'h60;
  localparam logic [7:0] OP_LEN4      = 8'h80;
  localparam logic [7:0] OP_EXPLICIT  = 8'hA0;
  localparam logic [7:0] OP_BAD       = 8'hD0;
  localparam logic [7:0] OP_BYTE_LAST = 8'h26;
  localparam logic [7:0] OP_WORD_LAST = 8'h42;
  localparam logic [7:0] OP_BV        = 8'h43;

  // Field codes.
  localparam logic [3:0] FIELD_WORD_BASE = 4'd7;
  localparam logic [3:0] FIELD_BV        = 4'd10;
  localparam int         NUM_FLAGS       = 10;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_NOLEN    = 3'd2,
    ST_BADOP    = 3'd3,
    ST_OVERRUN  = 3'd4,
    ST_DUP      = 3'd5,
    ST_IGNORED  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    WARN_NONE    = 2'd0,
    WARN_BV_OOR  = 2'd1,
    WARN_UNKNOWN = 2'd2
  } warning_e;

  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } item_t;

  // One result word.
  typedef struct packed {
    status_e     status;
    warning_e    warning;
    logic        field_valid;
    logic [3:0]  field_code;
    logic [15:0] field_value;
    logic [7:0]  bv_index;
  } result_t;

  // Outcome of decoding one completed command.
  typedef struct packed {
    logic        dup;
    logic        set_flag;
    warning_e    warning;
    logic        field_valid;
    logic [3:0]  field_code;
    logic [15:0] field_value;
    logic [7:0]  bv_index;
  } dispatch_t;

endpackage

FILE: rtl/core/scsc_in_stage.sv
// ----------------------------------------------------------------------------
// scsc_in_stage: input register
// Captures one stream word and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module scsc_in_stage import scsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  input  logic       take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // The register can load when it is empty or is being emptied this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.data_byte <= data_byte_i;
      item_q.is_last   <= is_last_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/scsc_parser.sv
// ----------------------------------------------------------------------------
// scsc_parser: command parser
// Holds the parse state and decodes one word per cycle, when fire_i is high.
// ----------------------------------------------------------------------------
module scsc_parser import scsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  phase_e                 phase_q, phase_d;
  logic [7:0]             op_q, op_d;
  logic [7:0]             rem_q, rem_d;
  logic [15:0]            pft_q, pft_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [NUM_FLAGS-1:0]   flags_q, flags_d;
  logic                   closed_q, closed_d;

  logic [7:0]  b;
  logic        last;
  logic [7:0]  dsp_op;
  logic [15:0] dsp_pft;
  logic [15:0] pft_upd;
  logic [7:0]  rem_upd;
  dispatch_t   dsp;
  result_t     res;

  assign b    = item_i.data_byte;
  assign last = item_i.is_last;

  // Payload bytes gathered so far, with the current byte merged in.
  always_comb begin
    pft_upd = pft_q;
    if (cnt_q == 2'd0) begin
      pft_upd = pft_q | {b, 8'h00};
    end else if (cnt_q == 2'd1) begin
      pft_upd = pft_q | {8'h00, b};
    end
  end

  assign rem_upd = rem_q - 8'd1;
  assign dsp_op  = (phase_q == PH_LENGTH || phase_q == PH_PAYLOAD) ? op_q : b;
  assign dsp_pft = (phase_q == PH_PAYLOAD) ? pft_upd : 16'h0000;

  // Decode of a completed command.
  always_comb begin
    dsp = '0;
    dsp.warning = WARN_NONE;
    if (dsp_op >= OP_LEN1 && dsp_op <= OP_BYTE_LAST) begin
      dsp.field_code  = {1'b0, dsp_op[2:0]};
      dsp.field_value = {8'h00, dsp_pft[15:8]};
    end else if (dsp_op >= OP_LEN2 && dsp_op <= OP_WORD_LAST) begin
      dsp.field_code  = FIELD_WORD_BASE + {2'b00, dsp_op[1:0]};
      dsp.field_value = dsp_pft;
    end else if (dsp_op == OP_BV) begin
      if ({1'b0, dsp_pft[15:8]} >= 9'(BV_SIZE)) begin
        dsp.warning = WARN_BV_OOR;
      end else begin
        dsp.field_valid = 1'b1;
        dsp.field_code  = FIELD_BV;
        dsp.field_value = {8'h00, dsp_pft[7:0]};
        dsp.bv_index    = dsp_pft[15:8];
      end
    end else begin
      dsp.warning = WARN_UNKNOWN;
    end
    if ((dsp_op >= OP_LEN1 && dsp_op <= OP_BYTE_LAST) ||
        (dsp_op >= OP_LEN2 && dsp_op <= OP_WORD_LAST)) begin
      if (flags_q[dsp.field_code]) begin
        dsp.dup         = 1'b1;
        dsp.field_code  = 4'd0;
        dsp.field_value = 16'h0000;
      end else begin
        dsp.field_valid = 1'b1;
        dsp.set_flag    = (dsp.field_value != 16'h0000);
      end
    end
  end

  // One parse step.
  always_comb begin
    logic       do_begin;
    logic       do_dispatch;
    logic [7:0] len;
    do_begin    = 1'b0;
    do_dispatch = 1'b0;
    len         = 8'd0;
    phase_d     = phase_q;
    op_d        = op_q;
    rem_d       = rem_q;
    pft_d       = pft_q;
    cnt_d       = cnt_q;
    flags_d     = flags_q;
    closed_d    = closed_q;
    res         = '0;
    res.status  = ST_BUSY;
    res.warning = WARN_NONE;

    if (closed_q) begin
      res.status = ST_IGNORED;
    end else begin
      case (phase_q)
        PH_LENGTH: begin
          do_begin = 1'b1;
          len      = b;
        end
        PH_PAYLOAD: begin
          pft_d = pft_upd;
          if (cnt_q != 2'd2) begin
            cnt_d = cnt_q + 2'd1;
          end
          rem_d = rem_upd;
          if (rem_upd == 8'd0) begin
            do_dispatch = 1'b1;
          end else if (last) begin
            res.status = ST_OVERRUN;
          end
        end
        default: begin
          op_d = b;
          if (b == OP_END) begin
            closed_d   = 1'b1;
            res.status = ST_OK;
          end else if (b < OP_EXPLICIT) begin
            do_begin = 1'b1;
            len      = {5'b00000, b[7:5]};
          end else if (b < OP_BAD) begin
            if (last) begin
              res.status = ST_NOLEN;
            end else begin
              phase_d = PH_LENGTH;
            end
          end else begin
            closed_d   = 1'b1;
            res.status = ST_BADOP;
          end
        end
      endcase

      if (do_begin) begin
        pft_d = 16'h0000;
        cnt_d = 2'd0;
        if (len == 8'd0) begin
          do_dispatch = 1'b1;
        end else if (last) begin
          res.status = ST_OVERRUN;
        end else begin
          phase_d = PH_PAYLOAD;
          rem_d   = len;
        end
      end

      if (do_dispatch) begin
        if (dsp.dup) begin
          closed_d   = 1'b1;
          res.status = ST_DUP;
        end else begin
          phase_d         = PH_OPCODE;
          res.status      = last ? ST_OK : ST_BUSY;
          res.warning     = dsp.warning;
          res.field_valid = dsp.field_valid;
          res.field_code  = dsp.field_code;
          res.field_value = dsp.field_value;
          res.bv_index    = dsp.bv_index;
          if (dsp.set_flag) begin
            flags_d = flags_q | (NUM_FLAGS'(1) << dsp.field_code);
          end
        end
      end
    end

    // The last word of a resource returns everything to reset.
    if (last) begin
      phase_d  = PH_OPCODE;
      op_d     = 8'h00;
      rem_d    = 8'h00;
      pft_d    = 16'h0000;
      cnt_d    = 2'd0;
      flags_d  = '0;
      closed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OPCODE;
      op_q     <= 8'h00;
      rem_q    <= 8'h00;
      pft_q    <= 16'h0000;
      cnt_q    <= 2'd0;
      flags_q  <= '0;
      closed_q <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      rem_q    <= rem_d;
      pft_q    <= pft_d;
      cnt_q    <= cnt_d;
      flags_q  <= flags_d;
      closed_q <= closed_d;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last |=> phase_q == PH_OPCODE && flags_q == '0 && !closed_q)
    else $error("parse state not cleared after the last word");

  a_field_no_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.field_valid |-> res.warning == WARN_NONE)
    else $error("field write and warning in the same result");

  a_ignored_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && closed_q |-> res.status == ST_IGNORED && !res.field_valid &&
    res.warning == WARN_NONE)
    else $error("closed stream produced an event");

  // A duplicate at the end of a payload closes the stream with the phase
  // left as it was, so the count only matters while the stream is open.
  a_payload_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD && !closed_q |-> rem_q != 8'd0)
    else $error("payload phase with no bytes remaining");
`endif

endmodule

FILE: rtl/core/scsc_out_stage.sv
// ----------------------------------------------------------------------------
// scsc_out_stage: result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module scsc_out_stage import scsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_valid_i,
  input  result_t res_i,
  output logic    advance_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // The register moves whenever it is empty or its word is being taken.
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/core/sprite_command_stream_checker.sv
// ----------------------------------------------------------------------------
// sprite_command_stream_checker: sprite command stream checker
// Parses a resource's command bytes one word at a time and reports status,
// warnings and field write events, one result word per input word.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o | data_byte_i, is_last_i
//   out     | output    | out_valid_o/out_stall_i | status_o, warning_o,
//           |           |                        | field_valid_o, field_code_o,
//           |           |                        | field_value_o, bv_index_o
//
// One word is accepted per clock when the output side does not stall.
// A result appears on the outputs once its word has been accepted into the
// input register and the parser has decoded it into the result register; a
// stall on the output can hold the word in the input register in between.
// Without output stalls the rate is one word per cycle; the parse step is
// combinational, with its state updated as a word enters the result register.
// Reset is asynchronous and active low; it empties both registers and puts
// the parser back to expecting an opcode on a fresh stream.
// A stall on the output holds both registers once the result register is full,
// and the input stalls only when its register is full and cannot move on.
// ----------------------------------------------------------------------------
module sprite_command_stream_checker import scsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  warning_o,
  output logic        field_valid_o,
  output logic [3:0]  field_code_o,
  output logic [15:0] field_value_o,
  output logic [7:0]  bv_index_o
);

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  logic    fire;
  result_t parse_res;
  result_t out_res;

  // A word is parsed when it sits in the input register and the result
  // register can take its result in the same cycle.
  assign fire = in_valid && advance;

  scsc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .take_i      (advance),
    .valid_o     (in_valid),
    .item_o      (in_item)
  );

  // The parser keeps all stream state and updates it only on fire, so the
  // order of results follows the order of accepted words exactly.
  scsc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item),
    .res_o  (parse_res)
  );

  scsc_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (fire),
    .res_i        (parse_res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (out_res)
  );

  assign status_o      = out_res.status;
  assign warning_o     = out_res.warning;
  assign field_valid_o = out_res.field_valid;
  assign field_code_o  = out_res.field_code;
  assign field_value_o = out_res.field_value;
  assign bv_index_o    = out_res.bv_index;

endmodule
